FILE: hdl/sira_pkg.sv
// shared constants, types and helper functions for the signed integer to ascii converter
package sira_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAX_CHARS   = VALUE_WIDTH + 1;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned IDX_W       = $clog2(VALUE_WIDTH);
  localparam int unsigned COUNT_W     = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned PROD_W      = 2 * VALUE_WIDTH;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'

  // 2^VALUE_WIDTH, numerator of the reciprocal table
  localparam logic [VALUE_WIDTH:0] RECIP_ONE = {1'b1, {VALUE_WIDTH{1'b0}}};

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StCorr = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  // clamp the register value into the supported radix range
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  // floor(2^VALUE_WIDTH / r) for r in 2..16
  function automatic logic [VALUE_WIDTH-1:0] recip(input logic [RADIX_W-1:0] r);
    case (r)
      5'd2:    return VALUE_WIDTH'(RECIP_ONE / 2);
      5'd3:    return VALUE_WIDTH'(RECIP_ONE / 3);
      5'd4:    return VALUE_WIDTH'(RECIP_ONE / 4);
      5'd5:    return VALUE_WIDTH'(RECIP_ONE / 5);
      5'd6:    return VALUE_WIDTH'(RECIP_ONE / 6);
      5'd7:    return VALUE_WIDTH'(RECIP_ONE / 7);
      5'd8:    return VALUE_WIDTH'(RECIP_ONE / 8);
      5'd9:    return VALUE_WIDTH'(RECIP_ONE / 9);
      5'd10:   return VALUE_WIDTH'(RECIP_ONE / 10);
      5'd11:   return VALUE_WIDTH'(RECIP_ONE / 11);
      5'd12:   return VALUE_WIDTH'(RECIP_ONE / 12);
      5'd13:   return VALUE_WIDTH'(RECIP_ONE / 13);
      5'd14:   return VALUE_WIDTH'(RECIP_ONE / 14);
      5'd15:   return VALUE_WIDTH'(RECIP_ONE / 15);
      default: return VALUE_WIDTH'(RECIP_ONE / 16);
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d <= DIGIT_W'(9)) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DIGIT_W'(10));
  endfunction

endpackage

FILE: hdl/signed_integer_to_radix_ascii.sv
// signed integer to ascii text converter in a programmable radix from 2 to 16
// steps: accept, then per digit a reciprocal multiply (StMul) and a correction (StCorr),
//   then the characters are registered one by one in StEmit, sign first
// a new value is accepted only in StIdle, once the last character of the previous
//   text is in the output register; the longest text is the most negative value in radix 2
// the digit loop runs on the shared multiply/correct datapath, one digit per pass
// reset: asynchronous active low, radix returns to 10, output channel empties
module signed_integer_to_radix_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                radix_we_i,
  input  logic [sira_pkg::RADIX_W-1:0]        radix_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sira_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sira_pkg::CHAR_W-1:0]         character_o,
  output logic                                last_o
);

  localparam int unsigned VW = sira_pkg::VALUE_WIDTH;
  localparam int unsigned RW = sira_pkg::RADIX_W;

  // control state
  sira_pkg::state_e                  state_q, state_d;
  logic [RW-1:0]                     radix_q, radix_d;
  logic [sira_pkg::COUNT_W-1:0]      count_q, count_d;
  logic                              sign_pend_q, sign_pend_d;
  logic                              out_valid_q, out_valid_d;

  // datapath state
  logic [VW-1:0]                     mag_q, mag_d;
  logic [VW-1:0]                     qest_q, qest_d;
  logic [sira_pkg::CHAR_W-1:0]       char_q, char_d;
  logic                              last_q, last_d;
  logic [sira_pkg::DIGIT_W-1:0]      digit_store_q [VW];

  // shared arithmetic
  logic [RW-1:0]                     rad;
  logic [sira_pkg::PROD_W-1:0]       prod;
  logic [VW+RW-1:0]                  qr;
  logic [VW-1:0]                     rem;
  logic                              rem_over;
  logic [VW-1:0]                     quot;
  logic [sira_pkg::DIGIT_W-1:0]      digit;
  logic                              store_we;
  logic [sira_pkg::IDX_W-1:0]        rd_idx;
  logic                              in_acc;
  logic                              out_free;

  assign rad = sira_pkg::eff_radix(radix_q);

  // quotient estimate: high half of magnitude times floor(2^32/r), low by at most one
  assign prod = sira_pkg::PROD_W'(mag_q) * sira_pkg::PROD_W'(sira_pkg::recip(rad));

  // remainder of the estimate stays below twice the radix, one compare fixes it
  assign qr       = (VW+RW)'(qest_q) * (VW+RW)'(rad);
  assign rem      = mag_q - qr[VW-1:0];
  assign rem_over = rem >= VW'(rad);
  assign quot     = rem_over ? qest_q + VW'(1) : qest_q;
  assign digit    = rem_over ? sira_pkg::DIGIT_W'(rem - VW'(rad))
                             : sira_pkg::DIGIT_W'(rem);

  assign in_ready_o  = (state_q == sira_pkg::StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign rd_idx      = sira_pkg::IDX_W'(count_q - sira_pkg::COUNT_W'(1));
  assign store_we    = (state_q == sira_pkg::StCorr);

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  always_comb begin
    state_d     = state_q;
    radix_d     = radix_we_i ? radix_wdata_i : radix_q;
    count_d     = count_q;
    sign_pend_d = sign_pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mag_d       = mag_q;
    qest_d      = qest_q;
    char_d      = char_q;
    last_d      = last_q;

    unique case (state_q)
      sira_pkg::StIdle: begin
        if (in_acc) begin
          sign_pend_d = value_i[VW-1];
          // two's complement magnitude, the most negative value gives 2^31
          mag_d       = value_i[VW-1] ? (~value_i + VW'(1)) : value_i;
          count_d     = '0;
          state_d     = sira_pkg::StMul;
        end
      end
      sira_pkg::StMul: begin
        qest_d  = prod[sira_pkg::PROD_W-1:VW];
        state_d = sira_pkg::StCorr;
      end
      sira_pkg::StCorr: begin
        // digit goes to the store at count_q, least significant first
        mag_d   = quot;
        count_d = count_q + sira_pkg::COUNT_W'(1);
        state_d = (quot == '0) ? sira_pkg::StEmit : sira_pkg::StMul;
      end
      sira_pkg::StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            // a sign is always followed by at least one digit
            char_d      = sira_pkg::CHAR_MINUS;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            // digits leave most significant first
            char_d  = sira_pkg::digit_char(digit_store_q[rd_idx]);
            last_d  = (count_q == sira_pkg::COUNT_W'(1));
            count_d = count_q - sira_pkg::COUNT_W'(1);
            if (count_q == sira_pkg::COUNT_W'(1)) begin
              state_d = sira_pkg::StIdle;
            end
          end
        end
      end
      default: begin
        state_d = sira_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sira_pkg::StIdle;
      radix_q     <= sira_pkg::RADIX_RESET;
      count_q     <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      count_q     <= count_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    qest_q <= qest_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // digit store, no reset, every entry is written before it is read
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      digit_store_q[count_q[sira_pkg::IDX_W-1:0]] <= digit;
    end
  end

  // the correction step always follows a multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sira_pkg::StCorr |-> $past(state_q) == sira_pkg::StMul)
    else $error("correction step without a preceding multiply");

  // an accepted item starts the digit loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == sira_pkg::StMul)
    else $error("accepted item did not start conversion");

  // never more digits than the store holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sira_pkg::COUNT_W'(VW))
    else $error("digit count overflow");

  // emitting always has a digit left to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sira_pkg::StEmit |-> count_q != '0)
    else $error("emit with no digits");

  // a string never ends on its sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> character_o != sira_pkg::CHAR_MINUS)
    else $error("string ends with a sign");

endmodule

FILE: tb/tb_signed_integer_to_radix_ascii.sv
// testbench for the signed integer to radix ascii converter: random traffic, scoreboard check
module tb_signed_integer_to_radix_ascii;

  // cycles with work outstanding but no item moving on either side
  localparam int unsigned HANG_LIMIT = 2000;
  // settle time after the last character before the next register write
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned VALUES_PER_PHASE = 20;

  // one expected character of the text for a value
  typedef struct packed {
    logic [sira_pkg::CHAR_W-1:0] character;
    logic                        last;
  } text_char_t;

  logic                                    clk_i         = 1'b0;
  logic                                    rst_ni        = 1'b0;
  logic                                    radix_we_i    = 1'b0;
  logic [sira_pkg::RADIX_W-1:0]            radix_wdata_i = '0;
  logic                                    in_valid_i    = 1'b0;
  logic                                    in_ready_o;
  logic signed [sira_pkg::VALUE_WIDTH-1:0] value_i       = '0;
  logic                                    out_valid_o;
  logic                                    out_ready_i   = 1'b0;
  logic [sira_pkg::CHAR_W-1:0]             character_o;
  logic                                    last_o;

  // values waiting to be sent, and characters waiting to come back
  logic [sira_pkg::VALUE_WIDTH-1:0] value_queue[$];
  text_char_t                       text_expected[$];

  // copy of the radix register as the block holds it
  logic [sira_pkg::RADIX_W-1:0] radix_shadow = sira_pkg::RADIX_RESET;
  // when set, neither side idles: back-to-back traffic
  bit                 steady = 1'b0;

  int unsigned send_gap      = 0;
  int unsigned ready_hold    = 0;
  int unsigned hang_cycles   = 0;
  int unsigned values_sent   = 0;
  int unsigned chars_checked = 0;
  int unsigned radix_writes  = 0;
  int unsigned mismatch_count = 0;

  signed_integer_to_radix_ascii i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radix_we_i   (radix_we_i),
    .radix_wdata_i(radix_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected text of one value: optional minus sign, then the digits of the
  // magnitude, most significant first, last flag on the final character
  function automatic void expand_to_text(input logic [sira_pkg::VALUE_WIDTH-1:0] value,
                                         input logic [sira_pkg::RADIX_W-1:0] radix_reg);
    longint unsigned base;
    longint unsigned rest;
    logic [sira_pkg::DIGIT_W-1:0] digits[$];
    logic [sira_pkg::DIGIT_W-1:0] d;
    text_char_t tc;
    // register values below two or above sixteen are clamped
    if (radix_reg < sira_pkg::RADIX_MIN) begin
      base = 64'(sira_pkg::RADIX_MIN);
    end else if (radix_reg > sira_pkg::RADIX_MAX) begin
      base = 64'(sira_pkg::RADIX_MAX);
    end else begin
      base = 64'(radix_reg);
    end
    // magnitude: the most negative value wraps to 2^31, which is still right unsigned
    rest = value[sira_pkg::VALUE_WIDTH-1] ? longint'(sira_pkg::VALUE_WIDTH'(-value))
                                          : longint'(value);
    // zero still gives one digit
    do begin
      digits.push_front(sira_pkg::DIGIT_W'(rest % base));
      rest = rest / base;
    end while (rest != 0);
    if (value[sira_pkg::VALUE_WIDTH-1]) begin
      tc.character = sira_pkg::CHAR_MINUS;
      tc.last      = 1'b0;
      text_expected.push_back(tc);
    end
    while (digits.size() != 0) begin
      d = digits.pop_front();
      tc.character = (d <= 9) ? sira_pkg::CHAR_ZERO + sira_pkg::CHAR_W'(d)
                              : sira_pkg::CHAR_A + sira_pkg::CHAR_W'(d - 10);
      tc.last      = (digits.size() == 0);
      text_expected.push_back(tc);
    end
  endfunction

  // random value: mostly short magnitudes of both signs, some full width and edge values
  function automatic logic [sira_pkg::VALUE_WIDTH-1:0] pick_value();
    logic [sira_pkg::VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 300);
      2: v = -sira_pkg::VALUE_WIDTH'($urandom_range(0, 300));
      3: v = $urandom() >> $urandom_range(0, 31);
      4: v = -($urandom() >> $urandom_range(0, 31));
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h8000_0001;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  // register write, only issued while the block is idle
  task automatic write_radix(input logic [sira_pkg::RADIX_W-1:0] r);
    @(posedge clk_i);
    radix_we_i    <= 1'b1;
    radix_wdata_i <= r;
    @(posedge clk_i);
    radix_we_i    <= 1'b0;
    radix_shadow  = r;
    radix_writes++;
    @(negedge clk_i);
  endtask

  // wait until every queued value has gone in and all of its text came back;
  // sampled on the falling edge so nothing is mid-update
  task automatic drain();
    @(negedge clk_i);
    while (value_queue.size() != 0 || in_valid_i || text_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // driver: draws a gap per item, holds valid and value until the block takes it
  always @(posedge clk_i) begin : driver_side
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expand_to_text(value_i, radix_shadow);
        values_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (value_queue.size() != 0) begin
          in_valid_i <= 1'b1;
          value_i    <= value_queue.pop_front();
          send_gap   <= steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each character against the oldest expectation,
  // then may drop ready for a randomly drawn number of cycles
  always @(posedge clk_i) begin : monitor_side
    text_char_t want;
    int unsigned hold;
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      chars_checked++;
      if (text_expected.size() == 0) begin
        $error("character 0x%02h last %0b with no text expected", character_o, last_o);
        mismatch_count++;
      end else begin
        want = text_expected.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected 0x%02h, got 0x%02h", want.character, character_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatch_count++;
        end
      end
      hold = steady ? 0 : $urandom_range(0, 3);
      out_ready_i <= (hold == 0);
      ready_hold  <= hold;
    end else if (!out_ready_i) begin
      out_ready_i <= (ready_hold <= 1);
      ready_hold  <= (ready_hold > 0) ? ready_hold - 1 : 0;
    end
  end

  // hang detection: only counts while something is still owed
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (value_queue.size() == 0 && !in_valid_i && text_expected.size() == 0)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    wait (hang_cycles >= HANG_LIMIT);
    $display("timeout: %0d values still queued, %0d characters outstanding",
             value_queue.size(), text_expected.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset radix of ten: zero, one, minus one, both extremes, a long negative
    value_queue.push_back(32'h0000_0000);
    value_queue.push_back(32'h0000_0001);
    value_queue.push_back(32'hFFFF_FFFF);
    value_queue.push_back(32'h7FFF_FFFF);
    value_queue.push_back(32'h8000_0000);
    value_queue.push_back(-32'sd123456789);
    drain();

    // binary: the most negative value gives the longest text, sign plus 32 digits
    write_radix(sira_pkg::RADIX_MIN);
    value_queue.push_back(32'h8000_0000);
    value_queue.push_back(32'h7FFF_FFFF);
    value_queue.push_back(32'h0000_0005);
    drain();

    // hex: letter digits A to F
    write_radix(sira_pkg::RADIX_MAX);
    value_queue.push_back(32'h0ABC_DEF9);
    value_queue.push_back(32'h8000_0000);
    value_queue.push_back(32'hFFFF_FFF1);
    drain();

    // register values below two behave as binary
    write_radix(5'd0);
    value_queue.push_back(32'h8000_0000);
    drain();
    write_radix(5'd1);
    value_queue.push_back(-32'sd6);
    drain();

    // register values above sixteen behave as hex
    write_radix(5'd17);
    value_queue.push_back(32'd255);
    drain();
    write_radix(5'd31);
    value_queue.push_back(32'hFFFF_FFFF);
    drain();

    // random phases: fresh radix each, some with no idling at all
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p % 4 == 3);
      write_radix(($urandom_range(0, 3) == 0)
                  ? sira_pkg::RADIX_W'($urandom_range(0, 31))
                  : sira_pkg::RADIX_W'($urandom_range(2, 16)));
      repeat (VALUES_PER_PHASE) value_queue.push_back(pick_value());
      drain();
    end
    steady = 1'b0;

    if (text_expected.size() != 0) begin
      $error("%0d characters never arrived", text_expected.size());
      mismatch_count++;
    end

    $display("converted %0d values into %0d checked characters", values_sent, chars_checked);
    $display("radix register written %0d times, clamped and edge settings included",
             radix_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
